>>> rtl/core/positional_list_engine_assert.svh
// Assertion macros for the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Checks that a property holds at every clock edge outside reset.
`define PLE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("list engine assertion failed");

// Checks that a consequent holds in the cycle after its trigger.
`define PLE_ASSERT_NEXT(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("list engine assertion failed");

`endif

>>> rtl/core/ple_pkg.sv
// Types, constants and codes shared by the list engine modules.
`default_nettype none
package ple_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int MODE_W   = 4;
   localparam int GRP_SIZE = 8;
   localparam int GRP_NUM  = CAPACITY / GRP_SIZE;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 4'd0,
      MODE_PUSH_BACK  = 4'd1,
      MODE_INSERT     = 4'd2,
      MODE_POP_FRONT  = 4'd3,
      MODE_POP_BACK   = 4'd4,
      MODE_ERASE      = 4'd5,
      MODE_READ_FRONT = 4'd6,
      MODE_READ_BACK  = 4'd7,
      MODE_READ_INDEX = 4'd8,
      MODE_READ_COUNT = 4'd9
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      op_type                   op;
      logic [CNT_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      logic                     rd_en;
      logic [CNT_W-1:0]         rd_pos;
   } cmd_type;

endpackage
`default_nettype wire

>>> rtl/core/ple_cell.sv
// One storage cell of the list: holds an entry and shifts with its neighbors.
`default_nettype none
module ple_cell
   import ple_pkg::*;
(
   input  wire logic                     clock,
   input  wire cmd_type                  cmd,
   input  wire logic [IDX_W-1:0]         cell_index,
   input  wire logic signed [DATA_W-1:0] left_value,
   input  wire logic signed [DATA_W-1:0] right_value,
   output logic signed [DATA_W-1:0]      entry_value,
   output logic signed [DATA_W-1:0]      rd_value
);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic [CNT_W-1:0]         my_pos;

   assign my_pos = CNT_W'(cell_index);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         OP_INSERT: begin
            // Cells past the insert point take the entry from below.
            if (my_pos > cmd.pos) begin
               entry_in = left_value;
            end else if (my_pos == cmd.pos) begin
               entry_in = cmd.value;
            end
         end
         OP_REMOVE: begin
            if (my_pos >= cmd.pos) begin
               entry_in = right_value;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
   assign rd_value    = (cmd.rd_en && (my_pos == cmd.rd_pos)) ? entry_ff : '0;

endmodule
`default_nettype wire

>>> rtl/core/ple_decode.sv
// Request decoder: checks a request against the count and builds the cell command.
`default_nettype none
module ple_decode
   import ple_pkg::*;
(
   input  wire logic [MODE_W-1:0]        mode,
   input  wire logic signed [DATA_W-1:0] value,
   input  wire logic [CNT_W-1:0]         position,
   input  wire logic [CNT_W-1:0]         count,
   output cmd_type                       cmd,
   output status_type                    status,
   output logic [CNT_W-1:0]              new_count
);

   logic             full;
   logic             empty;
   logic [CNT_W-1:0] last_pos;

   assign full     = count >= CNT_W'(CAPACITY);
   assign empty    = count == '0;
   assign last_pos = count - CNT_W'(1);

   always_comb begin
      cmd.op     = OP_HOLD;
      cmd.pos    = '0;
      cmd.value  = value;
      cmd.rd_en  = 1'b0;
      cmd.rd_pos = '0;
      status     = ST_OK;
      new_count  = count;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else if (mode == MODE_INSERT && position > count) begin
               status = ST_RANGE;
            end else begin
               cmd.op    = OP_INSERT;
               cmd.pos   = (mode == MODE_PUSH_FRONT) ? '0 :
                           (mode == MODE_PUSH_BACK)  ? count : position;
               new_count = count + CNT_W'(1);
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK, MODE_ERASE: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (mode == MODE_ERASE && position >= count) begin
               status = ST_RANGE;
            end else begin
               cmd.op     = OP_REMOVE;
               cmd.pos    = (mode == MODE_POP_FRONT) ? '0 :
                            (mode == MODE_POP_BACK)  ? last_pos : position;
               cmd.rd_en  = 1'b1;
               cmd.rd_pos = cmd.pos;
               new_count  = last_pos;
            end
         end
         MODE_READ_FRONT, MODE_READ_BACK, MODE_READ_INDEX: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (mode == MODE_READ_INDEX && position >= count) begin
               status = ST_RANGE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_pos = (mode == MODE_READ_FRONT) ? '0 :
                            (mode == MODE_READ_BACK)  ? last_pos : position;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/core/positional_list_engine.sv
// Top level of the list engine: decoder, chain of cells and result pipeline.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_mode, req_value, req_position
//   rsp      out        rsp_valid, rsp_ready, rsp_read_value, rsp_count, rsp_status
//
// The read value is gathered by an OR tree over the cells, registered per
// group of eight cells at acceptance and then once more in the result
// register. A new item is taken only after the last one has left the group
// registers and the result side keeps up. The cells shift in the cycle the
// item is accepted. Reset clears the count and valid flags only; entries
// need no clearing. A stalled result holds its register and blocks the next item.
`default_nettype none
`include "positional_list_engine_assert.svh"
module positional_list_engine
   import ple_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [MODE_W-1:0]        req_mode,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic [CNT_W-1:0]         req_position,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_read_value,
   output logic [CNT_W-1:0]              rsp_count,
   output logic [1:0]                    rsp_status
);

   logic                     accept;
   logic                     advance;
   cmd_type                  dec_cmd;
   cmd_type                  cell_cmd;
   status_type               dec_status;
   logic [CNT_W-1:0]         dec_count;

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;

   logic signed [DATA_W-1:0] entry_val [CAPACITY];
   logic signed [DATA_W-1:0] cell_rd   [CAPACITY];

   logic                     a_valid_ff;
   logic                     a_valid_in;
   logic signed [DATA_W-1:0] grp_ff [GRP_NUM];
   logic signed [DATA_W-1:0] grp_in [GRP_NUM];
   logic [CNT_W-1:0]         a_count_ff;
   status_type               a_status_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic signed [DATA_W-1:0] rsp_value_in;
   logic [CNT_W-1:0]         rsp_count_ff;
   status_type               rsp_status_ff;

   assign req_ready = !a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign advance   = a_valid_ff && (!rsp_valid_ff || rsp_ready);

   ple_decode u_decode (
      .mode      (req_mode),
      .value     (req_value),
      .position  (req_position),
      .count     (count_ff),
      .cmd       (dec_cmd),
      .status    (dec_status),
      .new_count (dec_count)
   );

   always_comb begin
      cell_cmd = dec_cmd;
      if (!accept) begin
         cell_cmd.op = OP_HOLD;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_v;
      logic signed [DATA_W-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = entry_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = entry_val[i+1];
      end
      ple_cell u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .cell_index  (IDX_W'(i)),
         .left_value  (left_v),
         .right_value (right_v),
         .entry_value (entry_val[i]),
         .rd_value    (cell_rd[i])
      );
   end

   // Only the addressed cell drives a nonzero read value.
   always_comb begin
      for (int g = 0; g < GRP_NUM; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GRP_SIZE; k++) begin
            grp_in[g] = grp_in[g] | cell_rd[g*GRP_SIZE + k];
         end
      end
   end

   always_comb begin
      rsp_value_in = '0;
      for (int g = 0; g < GRP_NUM; g++) begin
         rsp_value_in = rsp_value_in | grp_ff[g];
      end
   end

   assign count_in     = accept ? dec_count : count_ff;
   assign a_valid_in   = accept || (a_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         grp_ff      <= grp_in;
         a_count_ff  <= dec_count;
         a_status_ff <= dec_status;
      end
      if (advance) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= a_count_ff;
         rsp_status_ff <= a_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

   `PLE_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY))
   `PLE_ASSERT(a_one_in_flight, !(a_valid_ff && req_ready))
   `PLE_ASSERT_NEXT(a_insert_grows, accept && dec_cmd.op == OP_INSERT,
      count_ff == $past(count_ff) + CNT_W'(1))
   `PLE_ASSERT_NEXT(a_fail_keeps, accept && dec_status != ST_OK, $stable(count_ff))
   `PLE_ASSERT(a_fail_zero, !rsp_valid_ff || rsp_status_ff == ST_OK || rsp_value_ff == '0)

endmodule
`default_nettype wire
